FILE: hdl/stereo_modulated_delay_assert.svh
// assertion macros for the stereo modulated delay
`ifndef STEREO_MODULATED_DELAY_ASSERT_SVH
`define STEREO_MODULATED_DELAY_ASSERT_SVH

// same-cycle implication
`define SMD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/smd_pkg.sv
// shared constants and types of the stereo modulated delay
package smd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int DELAY_DEPTH = 8192;
    localparam int POS_BITS    = $clog2(DELAY_DEPTH);

    localparam int PHASE_BITS  = 32;
    localparam int FB_BITS     = 7;
    localparam int BASE_BITS   = 13;
    localparam int DEPTH_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int FB_SHIFT    = 6;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_LEFT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LFO_STEP     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOD_DEPTH    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_PHASE  = 3'd6;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [POS_BITS-1:0] pos_t;

endpackage

FILE: hdl/smd_ram.sv
// generic single-write, single-read ram with registered read data
module smd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/stereo_modulated_delay.sv
// top level of the stereo modulated delay (chorus / flanger)
//
// usage:
//   s_ channel takes one stereo pair (s_left_in, s_right_in) per transfer,
//   m_ channel returns one wet pair (m_left_out, m_right_out) per transfer.
//   cfg channel writes register cfg_index with cfg_data; always ready. the user
//   must write it only while the block is idle; the block does not enforce this.
// timing:
//   enabled: m_valid and s_ready rise together once both channels are done, so
//   no new pair is taken while one is in process. each channel takes
//   six steps through the one shared 33x17 multiplier and the delay ram read
//   port (lfo scale, two tap reads, interpolation, feedback scale, write).
//   bypass (enable low): the input pair goes unchanged to the output register,
//   and no new pair is taken until it is there.
// reset: config registers, lfo phase and write position clear; delay line entries
//   not yet written since reset read as zero, tracked by the write position
//   and a wrap flag, so no clearing pass is needed.
// stall: the result waits in the output register; a finished pair waits in
//   the sequencer until that register is free, and no new pair is taken.
`include "stereo_modulated_delay_assert.svh"

module stereo_modulated_delay
    import smd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TRI    = 3'd1;
    localparam logic [2:0] S_ADDR   = 3'd2;
    localparam logic [2:0] S_RDB    = 3'd3;
    localparam logic [2:0] S_DIFF   = 3'd4;
    localparam logic [2:0] S_INTERP = 3'd5;
    localparam logic [2:0] S_FB     = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    localparam int MUL_A_BITS = PHASE_BITS + 1;
    localparam int MUL_B_BITS = FRAC_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int N_BITS     = ((POS_BITS > BASE_BITS) ? POS_BITS : BASE_BITS) + 1;
    localparam int W_BITS     = SAMPLE_BITS + 2;

    localparam logic signed [W_BITS-1:0] W_MAX =
        {{(W_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [W_BITS-1:0] W_MIN =
        {{(W_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // configuration
    logic                         enable_reg;
    logic signed [FB_BITS-1:0]    fb_reg;
    logic [BASE_BITS-1:0]         base_left_reg;
    logic [BASE_BITS-1:0]         base_right_reg;
    logic [PHASE_BITS-1:0]        lfo_step_reg;
    logic [DEPTH_BITS-1:0]        depth_reg;
    logic [PHASE_BITS-1:0]        right_phase_reg;

    // sequencer and state
    logic [2:0]                   state_reg;
    logic                         ch_reg;
    logic [PHASE_BITS-1:0]        phase_reg;
    pos_t                         wp_reg;
    pos_t                         wp_next;
    logic                         full_reg;

    // datapath
    sample_t                      in_left_reg;
    sample_t                      in_right_reg;
    sample_t                      res_left_reg;
    sample_t                      res_right_reg;
    pos_t                         idx_reg;
    logic [FRAC_BITS-1:0]         frac_reg;
    sample_t                      a_reg;
    logic                         a_vld_reg;
    logic                         b_vld_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;

    logic [PHASE_BITS-1:0]        phase_ch;
    logic [PHASE_BITS-1:0]        phase_dbl;
    logic [PHASE_BITS-1:0]        tri_val;
    logic [N_BITS-1:0]            n_sum;
    pos_t                         idx_comb;
    pos_t                         idx_prev;
    pos_t                         raddr;
    sample_t                      rd_left;
    sample_t                      rd_right;
    sample_t                      rd_sel;
    sample_t                      b_val;
    logic signed [SAMPLE_BITS:0]  diff;
    sample_t                      out_comb;
    sample_t                      in_sel;
    logic signed [W_BITS-1:0]     fb_term;
    logic signed [W_BITS-1:0]     w_sum;
    sample_t                      w_sat;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic                         we_left;
    logic                         we_right;
    logic                         out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            fb_reg          <= '0;
            base_left_reg   <= '0;
            base_right_reg  <= '0;
            lfo_step_reg    <= '0;
            depth_reg       <= '0;
            right_phase_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ENABLE:      enable_reg      <= cfg_data[0];
                REG_FEEDBACK:    fb_reg          <= $signed(cfg_data[FB_BITS-1:0]);
                REG_BASE_LEFT:   base_left_reg   <= cfg_data[BASE_BITS-1:0];
                REG_BASE_RIGHT:  base_right_reg  <= cfg_data[BASE_BITS-1:0];
                REG_LFO_STEP:    lfo_step_reg    <= cfg_data[PHASE_BITS-1:0];
                REG_MOD_DEPTH:   depth_reg       <= cfg_data[DEPTH_BITS-1:0];
                REG_RIGHT_PHASE: right_phase_reg <= cfg_data[PHASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // triangle lfo
    assign phase_ch  = phase_reg + (ch_reg ? right_phase_reg : '0);
    assign phase_dbl = {phase_ch[PHASE_BITS-2:0], 1'b0};
    assign tri_val   = phase_ch[PHASE_BITS-1] ? ~phase_dbl : phase_dbl;

    // tap addresses
    assign n_sum = N_BITS'(prod_reg[PHASE_BITS +: DEPTH_BITS])
                 + N_BITS'(ch_reg ? base_right_reg : base_left_reg);
    assign idx_comb = wp_reg - n_sum[POS_BITS-1:0];
    assign idx_prev = idx_reg - POS_BITS'(1);
    assign raddr    = (state_reg == S_ADDR) ? idx_comb : idx_prev;
    assign wp_next  = wp_reg + POS_BITS'(1);

    // interpolation and feedback
    assign rd_sel   = ch_reg ? rd_right : rd_left;
    assign b_val    = b_vld_reg ? rd_sel : '0;
    assign diff     = (SAMPLE_BITS+1)'(b_val) - (SAMPLE_BITS+1)'(a_reg);
    assign out_comb = a_reg + $signed(prod_reg[FRAC_BITS +: SAMPLE_BITS]);
    assign in_sel   = ch_reg ? in_right_reg : in_left_reg;
    assign fb_term  = $signed(prod_reg[FB_SHIFT +: W_BITS]);
    assign w_sum    = W_BITS'(in_sel) + fb_term;

    always_comb begin
        if (w_sum > W_MAX) begin
            w_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (w_sum < W_MIN) begin
            w_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_sat = w_sum[SAMPLE_BITS-1:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        case (state_reg)
            S_TRI: begin
                mul_a = $signed({1'b0, tri_val});
                mul_b = $signed({{(MUL_B_BITS-DEPTH_BITS){1'b0}}, depth_reg});
            end
            S_DIFF: begin
                mul_a = MUL_A_BITS'(diff);
                mul_b = $signed({1'b0, frac_reg});
            end
            S_INTERP: begin
                mul_a = MUL_A_BITS'(out_comb);
                mul_b = MUL_B_BITS'(fb_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end

    assign we_left  = (state_reg == S_FB) && !ch_reg;
    assign we_right = (state_reg == S_FB) && ch_reg;

    smd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_left (
        .clk   (aclk),
        .we    (we_left),
        .waddr (wp_reg),
        .wdata (w_sat),
        .raddr (raddr),
        .rdata (rd_left)
    );

    smd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ram_right (
        .clk   (aclk),
        .we    (we_right),
        .waddr (wp_reg),
        .wdata (w_sat),
        .raddr (raddr),
        .rdata (rd_right)
    );

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                in_left_reg  <= s_left_in;
                in_right_reg <= s_right_in;
                res_left_reg  <= s_left_in;
                res_right_reg <= s_right_in;
            end
            S_ADDR: begin
                idx_reg   <= idx_comb;
                frac_reg  <= prod_reg[FRAC_BITS +: FRAC_BITS];
                a_vld_reg <= full_reg || (idx_comb < wp_reg);
            end
            S_RDB: begin
                a_reg     <= a_vld_reg ? rd_sel : '0;
                b_vld_reg <= full_reg || (idx_prev < wp_reg);
            end
            S_INTERP: begin
                if (ch_reg) begin
                    res_right_reg <= out_comb;
                end else begin
                    res_left_reg <= out_comb;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ch_reg    <= 1'b0;
            phase_reg <= '0;
            wp_reg    <= '0;
            full_reg  <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            if ((state_reg == S_OUT) && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    ch_reg <= 1'b0;
                    if (s_valid) begin
                        state_reg <= enable_reg ? S_TRI : S_OUT;
                    end
                end
                S_TRI:    state_reg <= S_ADDR;
                S_ADDR:   state_reg <= S_RDB;
                S_RDB:    state_reg <= S_DIFF;
                S_DIFF:   state_reg <= S_INTERP;
                S_INTERP: state_reg <= S_FB;
                S_FB: begin
                    if (!ch_reg) begin
                        ch_reg    <= 1'b1;
                        state_reg <= S_TRI;
                    end else begin
                        phase_reg <= phase_reg + lfo_step_reg;
                        wp_reg    <= wp_next;
                        if (wp_reg == POS_BITS'(DELAY_DEPTH - 1)) begin
                            full_reg <= 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && out_free) begin
            m_left_out  <= res_left_reg;
            m_right_out <= res_right_reg;
        end
    end

    `SMD_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while busy")
    `SMD_ASSERT_IMPL(a_ram_write_in_fb, aclk, aresetn, we_left || we_right, state_reg == S_FB && enable_reg, "delay line written outside feedback step")
    `SMD_ASSERT_NEXT(a_bypass_path, aclk, aresetn, s_valid && s_ready && !enable_reg, state_reg == S_OUT && $stable(wp_reg), "bypass entered processing")
    `SMD_ASSERT_NEXT(a_idle_holds_pos, aclk, aresetn, state_reg == S_IDLE, $stable(wp_reg) && $stable(phase_reg), "state moved while idle")

endmodule
